// ===== rtl/mqf_pkg.sv =====
// Package for the MQTT packet framer: request/result payload structs,
// back-end job descriptor, protocol byte constants. No dependencies.
`default_nettype none

package mqf_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_CONNECT   = 2'd0;
    localparam logic [1:0] REQ_PUBLISH   = 2'd1;
    localparam logic [1:0] REQ_SUBSCRIBE = 2'd2;
    localparam logic [1:0] REQ_DATA      = 2'd3;

    localparam int unsigned MAX_REMAINING_DEF = 127;
    localparam int unsigned QUEUE_DEPTH       = 4;

    // Fixed header and variable header bytes
    localparam logic [7:0] FH_CONNECT   = 8'h10;
    localparam logic [7:0] FH_PUBLISH   = 8'h30;
    localparam logic [7:0] FH_SUBSCRIBE = 8'h82;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] NAME_LEN_LO  = 8'h04;
    localparam logic [7:0] PROTO_LEVEL  = 8'h04;
    localparam logic [7:0] CHAR_M       = 8'h4D;
    localparam logic [7:0] CHAR_Q       = 8'h51;
    localparam logic [7:0] CHAR_T       = 8'h54;

    // Last byte index of each job kind
    localparam logic [3:0] LAST_IDX_CONNECT     = 4'd13;
    localparam logic [3:0] LAST_IDX_PUBLISH     = 4'd3;
    localparam logic [3:0] LAST_IDX_SUBSCRIBE   = 4'd5;
    localparam logic [3:0] LAST_IDX_SUBSCRIBE_Q = 4'd6;
    localparam logic [3:0] LAST_IDX_SINGLE      = 4'd0;
    localparam logic [3:0] LAST_IDX_DATA_QOS    = 4'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  string_len;
        logic [6:0]  body_len;
        logic [15:0] keepalive_or_id;
        logic [15:0] room;
        logic [7:0]  data_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
        logic [7:0] total_len;
    } pkt_item_t;

    typedef enum logic [2:0] {
        JOB_CONNECT   = 3'd0,
        JOB_PUBLISH   = 3'd1,
        JOB_SUBSCRIBE = 3'd2,
        JOB_ERROR     = 3'd3,
        JOB_DATA      = 3'd4,
        JOB_DATA_QOS  = 3'd5
    } job_kind_t;

    // One unit of back-end work: emits last_idx+1 bytes
    typedef struct packed {
        job_kind_t   kind;
        logic [3:0]  last_idx;
        logic        last_flag;  // final byte of this job ends the packet
        logic [7:0]  value;      // data byte, or remaining length for headers
        logic [6:0]  slen;
        logic [15:0] kid;
        logic [7:0]  total;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

endpackage

`default_nettype wire

// ===== rtl/mqtt_packet_framer.sv =====
// Top level of the MQTT 3.1.1 packet framer (CONNECT, PUBLISH and
// SUBSCRIBE at QoS 0). Depends on mqf_pkg, mqf_front, mqf_queue, mqf_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_ready | req_data  (mqf_pkg::req_item_t)
//   pkt     | out       | pkt_valid / pkt_ready | pkt_data  (mqf_pkg::pkt_item_t)
//
// Bytes: a data request yields one byte, two when it closes a subscribe
// topic and the QoS byte follows; a start request yields 14 bytes
// (connect), 4 (publish), 6 or 7 (subscribe) or 1 (error). The output
// register and the byte generator set the sustained rate of one byte per
// cycle, as long as a low pkt_ready does not hold the output register.
// Reset: rst_n clears phase, counters, queue pointers and output valid.
// Stalls: req_ready drops only when the job queue is full; the queue lets
// the front keep accepting while the back end waits on pkt_ready.
`default_nettype none

module mqtt_packet_framer #(
    parameter int unsigned MAX_REMAINING = mqf_pkg::MAX_REMAINING_DEF,
    parameter int unsigned QUEUE_DEPTH   = mqf_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire mqf_pkg::req_item_t req_data,
    output logic                    pkt_valid,
    input  wire logic               pkt_ready,
    output mqf_pkg::pkt_item_t      pkt_data
);

    mqf_pkg::job_push_t enq;
    mqf_pkg::job_t      head;
    logic               q_full;
    logic               head_valid;
    logic               pop;
    logic               accept;

    // A request is taken whenever the queue has a free slot; every request
    // produces at most one job.
    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;

    mqf_front #(
        .MAX_REMAINING (MAX_REMAINING)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req_data),
        .enq    (enq)
    );

    mqf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (enq),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mqf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt_data   (pkt_data)
    );

endmodule

`default_nettype wire

// ===== rtl/mqf_front.sv =====
// Front end: accepts requests, tracks packet phase, checks lengths and
// turns each request into a back-end job. Depends on mqf_pkg.
`default_nettype none

module mqf_front #(
    parameter int unsigned MAX_REMAINING = mqf_pkg::MAX_REMAINING_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire mqf_pkg::req_item_t req,
    output mqf_pkg::job_push_t      enq
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_STRING = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [6:0]  string_left_reg, string_left_next;
    logic [6:0]  body_left_reg, body_left_next;
    logic [7:0]  total_reg, total_next;

    logic [8:0]  rem;
    logic [8:0]  tot;
    logic        fits;
    logic [6:0]  sl_dec;
    logic [6:0]  bl_dec;
    mqf_pkg::job_t job;
    logic        push;

    always_comb
    begin
        unique case (req.req_type)
            mqf_pkg::REQ_CONNECT: rem = 9'd12 + {2'b00, req.string_len};
            mqf_pkg::REQ_PUBLISH: rem = 9'd2 + {2'b00, req.string_len}
                                        + {2'b00, req.body_len};
            default:              rem = 9'd5 + {2'b00, req.string_len};
        endcase
    end

    assign tot    = rem + 9'd2;
    assign fits   = (rem <= 9'(MAX_REMAINING)) && (req.room >= {7'b0, tot});
    assign sl_dec = string_left_reg - 7'd1;
    assign bl_dec = body_left_reg - 7'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        string_left_next = string_left_reg;
        body_left_next   = body_left_reg;
        total_next       = total_reg;
        push             = 1'b0;
        job.kind         = mqf_pkg::JOB_DATA;
        job.last_idx     = mqf_pkg::LAST_IDX_SINGLE;
        job.last_flag    = 1'b0;
        job.value        = req.data_byte;
        job.slen         = req.string_len;
        job.kid          = req.keepalive_or_id;
        job.total        = total_reg;

        if (accept)
        begin
            if (req.req_type == mqf_pkg::REQ_DATA)
            begin
                unique case (phase_reg)
                    PH_STRING:
                    begin
                        push             = 1'b1;
                        string_left_next = sl_dec;
                        if (sl_dec != 7'd0)
                        begin
                            job.kind = mqf_pkg::JOB_DATA;
                        end
                        else if (kind_reg == mqf_pkg::REQ_PUBLISH && body_left_reg != 7'd0)
                        begin
                            phase_next = PH_BODY;
                        end
                        else if (kind_reg == mqf_pkg::REQ_SUBSCRIBE)
                        begin
                            // topic done: append requested QoS byte
                            job.kind      = mqf_pkg::JOB_DATA_QOS;
                            job.last_idx  = mqf_pkg::LAST_IDX_DATA_QOS;
                            job.last_flag = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            job.last_flag = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                    PH_BODY:
                    begin
                        push           = 1'b1;
                        body_left_next = bl_dec;
                        if (bl_dec == 7'd0)
                        begin
                            job.last_flag = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        push = 1'b0;  // stray data byte outside a packet
                    end
                endcase
            end
            else if (!fits)
            begin
                push          = 1'b1;
                phase_next    = PH_IDLE;
                job.kind      = mqf_pkg::JOB_ERROR;
                job.last_flag = 1'b1;
                job.value     = mqf_pkg::BYTE_ZERO;
                job.total     = 8'd0;
            end
            else
            begin
                push             = 1'b1;
                kind_next        = req.req_type;
                total_next       = tot[7:0];
                string_left_next = req.string_len;
                body_left_next   = (req.req_type == mqf_pkg::REQ_PUBLISH) ?
                                   req.body_len : 7'd0;
                job.value        = rem[7:0];
                job.total        = tot[7:0];
                unique case (req.req_type)
                    mqf_pkg::REQ_CONNECT:
                    begin
                        job.kind      = mqf_pkg::JOB_CONNECT;
                        job.last_idx  = mqf_pkg::LAST_IDX_CONNECT;
                        job.last_flag = (req.string_len == 7'd0);
                        phase_next    = (req.string_len != 7'd0) ? PH_STRING : PH_IDLE;
                    end
                    mqf_pkg::REQ_PUBLISH:
                    begin
                        job.kind      = mqf_pkg::JOB_PUBLISH;
                        job.last_idx  = mqf_pkg::LAST_IDX_PUBLISH;
                        job.last_flag = (req.string_len == 7'd0) && (req.body_len == 7'd0);
                        if (req.string_len != 7'd0)
                            phase_next = PH_STRING;
                        else if (req.body_len != 7'd0)
                            phase_next = PH_BODY;
                        else
                            phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        job.kind      = mqf_pkg::JOB_SUBSCRIBE;
                        job.last_flag = (req.string_len == 7'd0);
                        job.last_idx  = (req.string_len == 7'd0) ?
                                        mqf_pkg::LAST_IDX_SUBSCRIBE_Q :
                                        mqf_pkg::LAST_IDX_SUBSCRIBE;
                        phase_next    = (req.string_len != 7'd0) ? PH_STRING : PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            kind_reg        <= 2'd0;
            string_left_reg <= 7'd0;
            body_left_reg   <= 7'd0;
            total_reg       <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            string_left_reg <= string_left_next;
            body_left_reg   <= body_left_next;
            total_reg       <= total_next;
        end
    end

    assign enq.push = push;
    assign enq.job  = job;

endmodule

`default_nettype wire

// ===== rtl/mqf_queue.sv =====
// Short job queue between front and back end of the framer.
// Depends on mqf_pkg.
`default_nettype none

module mqf_queue #(
    parameter int unsigned DEPTH = mqf_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mqf_pkg::job_push_t enq,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output mqf_pkg::job_t           head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mqf_pkg::job_t   mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = enq.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= enq.job;
    end

endmodule

`default_nettype wire

// ===== rtl/mqf_back.sv =====
// Back end: expands queued jobs into packet bytes, one per cycle unless
// pkt_ready holds the registered output stage. Depends on mqf_pkg.
`default_nettype none

module mqf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire mqf_pkg::job_t  head,
    output logic                pop,
    output logic                pkt_valid,
    input  wire logic           pkt_ready,
    output mqf_pkg::pkt_item_t  pkt_data
);

    logic [3:0]          idx_reg, idx_next;
    logic                valid_reg, valid_next;
    mqf_pkg::pkt_item_t  data_reg, data_next;
    logic                can_load;
    logic                fire;
    logic                final_beat;
    logic [7:0]          beat_byte;

    assign can_load   = !valid_reg || pkt_ready;
    assign fire       = head_valid && can_load;
    assign final_beat = (idx_reg == head.last_idx);
    assign pop        = fire && final_beat;

    always_comb
    begin
        beat_byte = mqf_pkg::BYTE_ZERO;
        unique case (head.kind)
            mqf_pkg::JOB_CONNECT:
            begin
                case (idx_reg)
                    4'd0:    beat_byte = mqf_pkg::FH_CONNECT;
                    4'd1:    beat_byte = head.value;
                    4'd3:    beat_byte = mqf_pkg::NAME_LEN_LO;
                    4'd4:    beat_byte = mqf_pkg::CHAR_M;
                    4'd5:    beat_byte = mqf_pkg::CHAR_Q;
                    4'd6:    beat_byte = mqf_pkg::CHAR_T;
                    4'd7:    beat_byte = mqf_pkg::CHAR_T;
                    4'd8:    beat_byte = mqf_pkg::PROTO_LEVEL;
                    4'd10:   beat_byte = head.kid[15:8];
                    4'd11:   beat_byte = head.kid[7:0];
                    4'd13:   beat_byte = {1'b0, head.slen};
                    default: beat_byte = mqf_pkg::BYTE_ZERO;  // flags, MSBs
                endcase
            end
            mqf_pkg::JOB_PUBLISH:
            begin
                case (idx_reg)
                    4'd0:    beat_byte = mqf_pkg::FH_PUBLISH;
                    4'd1:    beat_byte = head.value;
                    4'd3:    beat_byte = {1'b0, head.slen};
                    default: beat_byte = mqf_pkg::BYTE_ZERO;
                endcase
            end
            mqf_pkg::JOB_SUBSCRIBE:
            begin
                case (idx_reg)
                    4'd0:    beat_byte = mqf_pkg::FH_SUBSCRIBE;
                    4'd1:    beat_byte = head.value;
                    4'd2:    beat_byte = head.kid[15:8];
                    4'd3:    beat_byte = head.kid[7:0];
                    4'd5:    beat_byte = {1'b0, head.slen};
                    default: beat_byte = mqf_pkg::BYTE_ZERO;  // incl. QoS byte
                endcase
            end
            mqf_pkg::JOB_DATA_QOS:
            begin
                beat_byte = (idx_reg == 4'd0) ? head.value : mqf_pkg::BYTE_ZERO;
            end
            default:
            begin
                beat_byte = head.value;  // data byte, or zero for errors
            end
        endcase
    end

    always_comb
    begin
        data_next = data_reg;
        idx_next  = idx_reg;
        if (fire)
        begin
            data_next.out_byte  = beat_byte;
            data_next.last      = final_beat && head.last_flag;
            data_next.error     = (head.kind == mqf_pkg::JOB_ERROR);
            data_next.total_len = (final_beat && head.last_flag &&
                                   head.kind != mqf_pkg::JOB_ERROR) ? head.total : 8'd0;
            idx_next            = final_beat ? 4'd0 : idx_reg + 4'd1;
        end
        if (fire)
            valid_next = 1'b1;
        else if (pkt_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign pkt_valid = valid_reg;
    assign pkt_data  = data_reg;

endmodule

`default_nettype wire

// ===== dv/mqtt_packet_framer_tb.sv =====
// Self-checking testbench for mqtt_packet_framer: directed table, then random
// packet sequences with noise, checked byte by byte against a local framer model.
// Depends on mqf_pkg and the mqtt_packet_framer RTL only.
`default_nettype none

module mqtt_packet_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mqf_pkg::*;

    // Run shape
    localparam int N_DIR          = 25;
    localparam int TARGET_ITEMS   = N_DIR + 310;  // counted requests, ignored ones excluded
    localparam int HOLD_AT        = 100;          // receiver goes quiet here
    localparam int PAUSE_AT       = 200;          // sender drains the framer here
    localparam int QUIET_AT       = 290;          // no idling from here on
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 2000;         // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 32;

    // How a directed row gets its expected bytes
    localparam int EXP_PREDICT = -1;  // from the framer model
    localparam int EXP_NONE    = 0;   // request is dropped, nothing comes out
    localparam int EXP_TYPED   = 1;   // exactly the one result typed in the row

    localparam pkt_item_t ERR_RESULT = '{out_byte: BYTE_ZERO, last: 1'b1, error: 1'b1,
                                         total_len: 8'h00};
    localparam pkt_item_t NO_RESULT  = '0;

    typedef enum logic [1:0] {FR_IDLE, FR_STRING, FR_BODY} frame_phase_t;

    typedef struct {
        req_item_t req;
        int        n_typed;
        pkt_item_t typed;
    } dir_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req_data  = '0;
    logic      pkt_valid;
    logic      pkt_ready = 1'b0;
    pkt_item_t pkt_data;

    // Framer model state
    frame_phase_t fr_phase     = FR_IDLE;
    logic [1:0]   fr_kind      = '0;
    logic [6:0]   fr_str_left  = '0;
    logic [6:0]   fr_body_left = '0;
    logic [7:0]   fr_total     = '0;

    pkt_item_t   frame_bytes_q[$];   // bytes the model produced for the last request
    pkt_item_t   pkt_expect_q[$];    // bytes still owed by the DUT, oldest first
    int unsigned mismatches  = 0;
    int unsigned item_cnt    = 0;
    int unsigned stall_cnt   = 0;
    bit          quiet_tail  = 1'b0;
    bit          rx_hold_req = 1'b0;

    always #5 clk = ~clk;

    mqtt_packet_framer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt_data  (pkt_data)
    );

    // ------------------------------------------------------------------
    // Framer model
    // ------------------------------------------------------------------

    // Non-error byte; total_len only rides on the packet's final byte.
    function automatic void emit(logic [7:0] b, logic last, logic [7:0] tot);
        pkt_item_t p;
        p.out_byte  = b;
        p.last      = last;
        p.error     = 1'b0;
        p.total_len = last ? tot : 8'h00;
        frame_bytes_q.push_back(p);
    endfunction

    function automatic void frame_request(req_item_t r);
        int rem;
        int tot;
        frame_bytes_q.delete();

        if (r.req_type == REQ_DATA)
        begin
            case (fr_phase)
                FR_STRING:
                begin
                    fr_str_left = fr_str_left - 7'd1;
                    if (fr_str_left != 7'd0)
                    begin
                        emit(r.data_byte, 1'b0, 8'h00);
                    end
                    else if (fr_kind == REQ_PUBLISH && fr_body_left != 7'd0)
                    begin
                        // topic done, payload follows
                        emit(r.data_byte, 1'b0, 8'h00);
                        fr_phase = FR_BODY;
                    end
                    else if (fr_kind == REQ_SUBSCRIBE)
                    begin
                        // topic done, requested-QoS byte closes the packet
                        emit(r.data_byte, 1'b0, 8'h00);
                        emit(BYTE_ZERO, 1'b1, fr_total);
                        fr_phase = FR_IDLE;
                    end
                    else
                    begin
                        emit(r.data_byte, 1'b1, fr_total);
                        fr_phase = FR_IDLE;
                    end
                end
                FR_BODY:
                begin
                    fr_body_left = fr_body_left - 7'd1;
                    emit(r.data_byte, fr_body_left == 7'd0, fr_total);
                    if (fr_body_left == 7'd0)
                        fr_phase = FR_IDLE;
                end
                default: ;  // data with no open packet is dropped
            endcase
            return;
        end

        // Start request: any open packet is abandoned here
        case (r.req_type)
            REQ_CONNECT: rem = 12 + int'(r.string_len);
            REQ_PUBLISH: rem = 2 + int'(r.string_len) + int'(r.body_len);
            default:     rem = 5 + int'(r.string_len);
        endcase
        tot = rem + 2;

        if (rem > int'(MAX_REMAINING_DEF) || int'(r.room) < tot)
        begin
            fr_phase = FR_IDLE;
            frame_bytes_q.push_back(ERR_RESULT);
            return;
        end

        fr_kind      = r.req_type;
        fr_total     = 8'(tot);
        fr_str_left  = r.string_len;
        fr_body_left = (r.req_type == REQ_PUBLISH) ? r.body_len : 7'd0;

        case (r.req_type)
            REQ_CONNECT:
            begin
                emit(FH_CONNECT, 1'b0, 8'h00);
                emit(8'(rem), 1'b0, 8'h00);
                emit(BYTE_ZERO, 1'b0, 8'h00);
                emit(NAME_LEN_LO, 1'b0, 8'h00);
                emit(CHAR_M, 1'b0, 8'h00);
                emit(CHAR_Q, 1'b0, 8'h00);
                emit(CHAR_T, 1'b0, 8'h00);
                emit(CHAR_T, 1'b0, 8'h00);
                emit(PROTO_LEVEL, 1'b0, 8'h00);
                emit(BYTE_ZERO, 1'b0, 8'h00);       // connect flags
                emit(r.keepalive_or_id[15:8], 1'b0, 8'h00);
                emit(r.keepalive_or_id[7:0], 1'b0, 8'h00);
                emit(BYTE_ZERO, 1'b0, 8'h00);       // client id length, high
                emit({1'b0, r.string_len}, r.string_len == 7'd0, 8'(tot));
                fr_phase = (r.string_len != 7'd0) ? FR_STRING : FR_IDLE;
            end
            REQ_PUBLISH:
            begin
                emit(FH_PUBLISH, 1'b0, 8'h00);
                emit(8'(rem), 1'b0, 8'h00);
                emit(BYTE_ZERO, 1'b0, 8'h00);
                emit({1'b0, r.string_len}, r.string_len == 7'd0 && r.body_len == 7'd0,
                     8'(tot));
                if (r.string_len != 7'd0)
                    fr_phase = FR_STRING;
                else if (r.body_len != 7'd0)
                    fr_phase = FR_BODY;
                else
                    fr_phase = FR_IDLE;
            end
            default:
            begin
                emit(FH_SUBSCRIBE, 1'b0, 8'h00);
                emit(8'(rem), 1'b0, 8'h00);
                emit(r.keepalive_or_id[15:8], 1'b0, 8'h00);
                emit(r.keepalive_or_id[7:0], 1'b0, 8'h00);
                emit(BYTE_ZERO, 1'b0, 8'h00);
                emit({1'b0, r.string_len}, 1'b0, 8'h00);
                if (r.string_len != 7'd0)
                begin
                    fr_phase = FR_STRING;
                end
                else
                begin
                    emit(BYTE_ZERO, 1'b1, 8'(tot));  // empty topic: QoS byte ends it
                    fr_phase = FR_IDLE;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic req_item_t req_at(logic [1:0] kind, logic [6:0] slen,
                                         logic [6:0] blen, logic [15:0] kid,
                                         logic [15:0] room, logic [7:0] db);
        req_item_t r;
        r.req_type        = kind;
        r.string_len      = slen;
        r.body_len        = blen;
        r.keepalive_or_id = kid;
        r.room            = room;
        r.data_byte       = db;
        return r;
    endfunction

    // Offer one request, hold it until accepted, then book its expected bytes.
    // valid stays high into the next request unless an idle burst follows.
    task automatic send_request(input req_item_t r, input int n_typed,
                                input pkt_item_t typed);
        int gap;
        req_data  <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);

        if (!(r.req_type == REQ_DATA && fr_phase == FR_IDLE))
            item_cnt++;
        frame_request(r);
        if (n_typed == EXP_PREDICT)
        begin
            foreach (frame_bytes_q[i])
                pkt_expect_q.push_back(frame_bytes_q[i]);
        end
        else if (n_typed == EXP_TYPED)
        begin
            pkt_expect_q.push_back(typed);
        end

        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One start request plus the data bytes it calls for. Mostly small,
    // well-formed packets; some oversized, some tight on room, some cut short.
    task automatic send_packet();
        req_item_t  r;
        logic [1:0] kind;
        int         pick;
        int         rem;
        int         n_data;
        kind = 2'($urandom_range(0, 2));
        r = req_at(kind, 7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)),
                   16'($urandom), 16'h0000, 8'($urandom));

        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // anything goes, at times over the limit
            r.string_len = 7'($urandom);
            r.body_len   = 7'($urandom);
        end
        else if (pick < 14)
        begin
            // long but legal
            case (kind)
                REQ_CONNECT: r.string_len = 7'($urandom_range(0, 115));
                REQ_PUBLISH:
                begin
                    r.string_len = 7'($urandom_range(0, 125));
                    r.body_len   = 7'($urandom_range(0, 125 - int'(r.string_len)));
                end
                default:     r.string_len = 7'($urandom_range(0, 122));
            endcase
        end

        case (kind)
            REQ_CONNECT: rem = 12 + int'(r.string_len);
            REQ_PUBLISH: rem = 2 + int'(r.string_len) + int'(r.body_len);
            default:     rem = 5 + int'(r.string_len);
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 10)
            r.room = 16'(rem + 2);            // exact fit
        else if (pick < 18)
            r.room = 16'(rem + 1);            // one byte short
        else if (pick < 24)
            r.room = 16'($urandom);
        else
            r.room = 16'($urandom_range(65535, rem + 2));

        send_request(r, EXP_PREDICT, NO_RESULT);

        n_data = 0;
        if (fr_phase != FR_IDLE)
            n_data = int'(r.string_len) + (kind == REQ_PUBLISH ? int'(r.body_len) : 0);
        if (n_data > 0 && $urandom_range(0, 99) < 12)
            n_data = $urandom_range(0, n_data - 1);   // broken packet

        repeat (n_data)
        begin
            r = req_at(REQ_DATA, 7'($urandom), 7'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom));
            send_request(r, EXP_PREDICT, NO_RESULT);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        int burst;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            if (rx_hold_req && !hold_done)
            begin
                // long stall so the job queue fills and req_ready drops
                hold_done = 1'b1;
                pkt_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 12);
                pkt_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 20);
                pkt_ready <= 1'b1;
                repeat (burst) @(posedge clk);
            end
        end
    end

    // Check every accepted byte against the oldest booked expectation
    always @(posedge clk)
    begin : pkt_check
        pkt_item_t want;
        if (rst_n && pkt_valid && pkt_ready)
        begin
            if (pkt_expect_q.size() == 0)
            begin
                $error("unexpected result: out_byte %0h last %0b error %0b total_len %0d",
                       pkt_data.out_byte, pkt_data.last, pkt_data.error,
                       pkt_data.total_len);
                mismatches++;
            end
            else
            begin
                want = pkt_expect_q.pop_front();
                if (pkt_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, actual %0h",
                           want.out_byte, pkt_data.out_byte);
                    mismatches++;
                end
                if (pkt_data.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, pkt_data.last);
                    mismatches++;
                end
                if (pkt_data.error !== want.error)
                begin
                    $error("error: expected %0b, actual %0b", want.error, pkt_data.error);
                    mismatches++;
                end
                if (pkt_data.total_len !== want.total_len)
                begin
                    $error("total_len: expected %0d, actual %0d",
                           want.total_len, pkt_data.total_len);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any handshake on either side counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (pkt_valid && pkt_ready))
            begin
                stall_cnt <= 0;
            end
            else if (stall_cnt >= STALL_LIMIT)
            begin
                $display("mqtt_packet_framer regression: fail");
                $finish;
            end
            else
            begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t   dir_tab [N_DIR];
        req_item_t  noise_req;
        logic [63:0] noise;
        bit         held;
        bit         paused;
        held   = 1'b0;
        paused = 1'b0;

        // Directed rows. Typed results only where obvious: dropped data and errors.
        dir_tab = '{
            // data with no packet open right after reset
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'hFF),
              EXP_NONE, NO_RESULT},
            // connect, empty client id, exact room, ignored body_len at max
            '{req_at(REQ_CONNECT,   7'd0,   7'd127, 16'hFFFF, 16'd14,   8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_CONNECT,   7'd1,   7'd0,   16'h0000, 16'd15,   8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'hA5),
              EXP_PREDICT, NO_RESULT},
            // remaining length 128: too long
            '{req_at(REQ_CONNECT,   7'd116, 7'd0,   16'h0000, 16'hFFFF, 8'h00),
              EXP_TYPED, ERR_RESULT},
            // empty publish, exact room
            '{req_at(REQ_PUBLISH,   7'd0,   7'd0,   16'hFFFF, 16'd4,    8'hFF),
              EXP_PREDICT, NO_RESULT},
            // no room at all
            '{req_at(REQ_PUBLISH,   7'd0,   7'd0,   16'h0000, 16'h0000, 8'h00),
              EXP_TYPED, ERR_RESULT},
            '{req_at(REQ_PUBLISH,   7'd1,   7'd1,   16'h5555, 16'd6,    8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h5A),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 8'hC3),
              EXP_PREDICT, NO_RESULT},
            // both lengths at max
            '{req_at(REQ_PUBLISH,   7'd127, 7'd127, 16'h0000, 16'hFFFF, 8'h00),
              EXP_TYPED, ERR_RESULT},
            // empty subscribe: QoS byte carries last
            '{req_at(REQ_SUBSCRIBE, 7'd0,   7'd0,   16'h8001, 16'd9,    8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_SUBSCRIBE, 7'd1,   7'd0,   16'h00FF, 16'd8,    8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h7E),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_SUBSCRIBE, 7'd123, 7'd0,   16'h1234, 16'hFFFF, 8'h00),
              EXP_TYPED, ERR_RESULT},
            // connect cut short by a new publish start
            '{req_at(REQ_CONNECT,   7'd3,   7'd0,   16'h1234, 16'hFFFF, 8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h11),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_PUBLISH,   7'd0,   7'd2,   16'h0000, 16'hFFFF, 8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h22),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h33),
              EXP_PREDICT, NO_RESULT},
            // packet closed: this byte is dropped
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h44),
              EXP_NONE, NO_RESULT},
            // subscribe aborted by an error start, then stray data
            '{req_at(REQ_SUBSCRIBE, 7'd2,   7'd0,   16'hABCD, 16'hFFFF, 8'h00),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h01),
              EXP_PREDICT, NO_RESULT},
            '{req_at(REQ_CONNECT,   7'd127, 7'd0,   16'h0000, 16'hFFFF, 8'h00),
              EXP_TYPED, ERR_RESULT},
            '{req_at(REQ_DATA,      7'd0,   7'd0,   16'h0000, 16'h0000, 8'h02),
              EXP_NONE, NO_RESULT}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIR; k++)
            send_request(dir_tab[k].req, dir_tab[k].n_typed, dir_tab[k].typed);

        while (item_cnt < TARGET_ITEMS)
        begin
            if (!held && item_cnt >= HOLD_AT)
            begin
                held        = 1'b1;
                rx_hold_req = 1'b1;   // sender keeps going meanwhile
            end
            if (!paused && item_cnt >= PAUSE_AT)
            begin
                // let the framer empty out completely before going on
                paused = 1'b1;
                req_valid <= 1'b0;
                do @(posedge clk); while (pkt_expect_q.size() != 0);
            end
            quiet_tail = (item_cnt >= QUIET_AT);

            if ($urandom_range(0, 99) < 8)
            begin
                noise     = {$urandom, $urandom};
                noise_req = noise[$bits(req_item_t)-1:0];
                send_request(noise_req, EXP_PREDICT, NO_RESULT);
            end
            else
            begin
                send_packet();
            end
        end
        req_valid <= 1'b0;

        while (pkt_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("mqtt_packet_framer regression: pass");
        else
            $display("mqtt_packet_framer regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
